/* hdl/stt_pkg.sv */
// Shared types, token kinds and character codes for the source text tokenizer.
package stt_pkg;

	// One input item: a source byte and the end-of-source mark.
	typedef struct packed {
		logic [7:0] source_byte;
		logic       last_byte;
	} src_item_t;

	// One result item: a token.
	typedef struct packed {
		logic [4:0]  token_kind;
		logic [15:0] line_number;
		logic [15:0] lexeme_start;
		logic [15:0] lexeme_length;
		logic        last_token;
	} token_t;

	typedef enum logic [3:0] {
		MODE_IDLE,
		MODE_OP,
		MODE_DOT,
		MODE_STR,
		MODE_WORD,
		MODE_INT,
		MODE_FLOAT,
		MODE_ERR
	} scan_mode_t;

	// First five bytes of an identifier; length saturates at 6 (longer than five).
	typedef struct packed {
		logic [2:0]  length;
		logic [39:0] prefix;
	} word_t;

	typedef struct packed {
		scan_mode_t  mode;
		logic [7:0]  pending_char;
		logic [15:0] line_count;
		word_t       word;
	} scan_state_t;

	localparam int          MAX_RESULTS    = 3;
	localparam logic [15:0] FIRST_LINE_RST = 16'd1;
	localparam logic [15:0] LINE_MAX       = 16'hFFFF;

	// Token kinds
	localparam logic [4:0] K_PLUS          = 5'd0;
	localparam logic [4:0] K_MINUS         = 5'd1;
	localparam logic [4:0] K_SLASH         = 5'd2;
	localparam logic [4:0] K_STAR          = 5'd3;
	localparam logic [4:0] K_SEMICOLON     = 5'd4;
	localparam logic [4:0] K_LEFT_PAREN    = 5'd5;
	localparam logic [4:0] K_RIGHT_PAREN   = 5'd6;
	localparam logic [4:0] K_LEFT_BRACE    = 5'd7;
	localparam logic [4:0] K_RIGHT_BRACE   = 5'd8;
	localparam logic [4:0] K_MOD           = 5'd9;
	localparam logic [4:0] K_DOT           = 5'd10;
	localparam logic [4:0] K_EQUAL         = 5'd12;
	localparam logic [4:0] K_LESS          = 5'd14;
	localparam logic [4:0] K_GREATER       = 5'd16;
	localparam logic [4:0] K_BANG          = 5'd18;
	localparam logic [4:0] K_PRINT         = 5'd19;
	localparam logic [4:0] K_IF            = 5'd20;
	localparam logic [4:0] K_ELSE          = 5'd21;
	localparam logic [4:0] K_TRUE          = 5'd22;
	localparam logic [4:0] K_FALSE         = 5'd23;
	localparam logic [4:0] K_NIL           = 5'd24;
	localparam logic [4:0] K_EOF           = 5'd25;
	localparam logic [4:0] K_STRING        = 5'd26;
	localparam logic [4:0] K_IDENT         = 5'd27;
	localparam logic [4:0] K_FLOAT         = 5'd28;
	localparam logic [4:0] K_INT           = 5'd29;
	localparam logic [4:0] K_BADCHAR       = 5'd30;
	localparam logic [4:0] K_UNCLOSED      = 5'd31;

	// Keywords, first character in the low byte, zero padded
	localparam logic [39:0] KW_PRINT = 40'h74_6e_69_72_70;
	localparam logic [39:0] KW_IF    = 40'h00_00_00_66_69;
	localparam logic [39:0] KW_ELSE  = 40'h00_65_73_6c_65;
	localparam logic [39:0] KW_TRUE  = 40'h00_65_75_72_74;
	localparam logic [39:0] KW_FALSE = 40'h65_73_6c_61_66;
	localparam logic [39:0] KW_NIL   = 40'h00_00_6c_69_6e;

	// Character codes
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;

endpackage

/* hdl/stt_step.sv */
// Per-byte scan logic: next scanner state and up to three tokens for one byte.
module stt_step #(
	parameter int          POS_W     = 17,
	parameter int unsigned MAX_BYTES = 65536
) (
	input  stt_pkg::scan_state_t                           state,
	input  logic [POS_W-1:0]                               pos,
	input  logic [POS_W:0]                                 tok_start,
	input  logic [15:0]                                    first_line,
	input  stt_pkg::src_item_t                             item,
	output stt_pkg::scan_state_t                           next_state,
	output logic [POS_W-1:0]                               next_pos,
	output logic [POS_W:0]                                 next_start,
	output stt_pkg::token_t [stt_pkg::MAX_RESULTS-1:0]     tokens,
	output logic [1:0]                                     count
);

	localparam int XW = (POS_W + 1 > 16) ? POS_W + 1 : 17;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= stt_pkg::CH_0) && (c <= stt_pkg::CH_9);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return ((c >= stt_pkg::CH_LA) && (c <= stt_pkg::CH_LZ)) ||
		       ((c >= stt_pkg::CH_UA) && (c <= stt_pkg::CH_UZ)) ||
		       (c == stt_pkg::CH_UNDER);
	endfunction

	function automatic stt_pkg::word_t word_add(stt_pkg::word_t w, logic [7:0] c);
		stt_pkg::word_t r;
		r = w;
		if (w.length < 3'd5) begin
			r.prefix = w.prefix | (40'(c) << {w.length, 3'b000});
			r.length = w.length + 3'd1;
		end else begin
			r.length = 3'd6;
		end
		return r;
	endfunction

	function automatic logic [4:0] word_kind(stt_pkg::word_t w);
		if (w == {3'd5, stt_pkg::KW_PRINT}) return stt_pkg::K_PRINT;
		if (w == {3'd2, stt_pkg::KW_IF})    return stt_pkg::K_IF;
		if (w == {3'd4, stt_pkg::KW_ELSE})  return stt_pkg::K_ELSE;
		if (w == {3'd4, stt_pkg::KW_TRUE})  return stt_pkg::K_TRUE;
		if (w == {3'd5, stt_pkg::KW_FALSE}) return stt_pkg::K_FALSE;
		if (w == {3'd3, stt_pkg::KW_NIL})   return stt_pkg::K_NIL;
		return stt_pkg::K_IDENT;
	endfunction

	function automatic logic [4:0] single_op(logic [7:0] c);
		logic [4:0] k;
		case (c)
			stt_pkg::CH_EQ: k = stt_pkg::K_EQUAL;
			stt_pkg::CH_LT: k = stt_pkg::K_LESS;
			stt_pkg::CH_GT: k = stt_pkg::K_GREATER;
			default:        k = stt_pkg::K_BANG;
		endcase
		return k;
	endfunction

	// {hit, kind} for operators that are complete in one byte
	function automatic logic [5:0] simple_op(logic [7:0] c);
		logic [5:0] r;
		case (c)
			stt_pkg::CH_PLUS:   r = {1'b1, stt_pkg::K_PLUS};
			stt_pkg::CH_MINUS:  r = {1'b1, stt_pkg::K_MINUS};
			stt_pkg::CH_SLASH:  r = {1'b1, stt_pkg::K_SLASH};
			stt_pkg::CH_STAR:   r = {1'b1, stt_pkg::K_STAR};
			stt_pkg::CH_SEMI:   r = {1'b1, stt_pkg::K_SEMICOLON};
			stt_pkg::CH_LPAREN: r = {1'b1, stt_pkg::K_LEFT_PAREN};
			stt_pkg::CH_RPAREN: r = {1'b1, stt_pkg::K_RIGHT_PAREN};
			stt_pkg::CH_LBRACE: r = {1'b1, stt_pkg::K_LEFT_BRACE};
			stt_pkg::CH_RBRACE: r = {1'b1, stt_pkg::K_RIGHT_BRACE};
			stt_pkg::CH_PCT:    r = {1'b1, stt_pkg::K_MOD};
			default:            r = 6'd0;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] sat16(logic [XW-1:0] v);
		return (v > XW'(16'hFFFF)) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic [POS_W:0] span(logic [POS_W-1:0] e, logic [POS_W:0] ts);
		logic [POS_W:0] ex;
		ex = {1'b0, e};
		return (ex > ts) ? ex - ts : '0;
	endfunction

	function automatic stt_pkg::token_t make_tok(logic [4:0] k, logic [15:0] ln,
			logic [POS_W:0] st, logic [POS_W:0] len);
		stt_pkg::token_t r;
		r.token_kind    = k;
		r.line_number   = ln;
		r.lexeme_start  = sat16(XW'(st));
		r.lexeme_length = sat16(XW'(len));
		r.last_token    = 1'b0;
		return r;
	endfunction

	function automatic logic close_has(stt_pkg::scan_mode_t m);
		return (m == stt_pkg::MODE_OP) || (m == stt_pkg::MODE_DOT) ||
		       (m == stt_pkg::MODE_WORD) || (m == stt_pkg::MODE_INT) ||
		       (m == stt_pkg::MODE_FLOAT);
	endfunction

	// Token that closes the open lexeme whose last byte lies before offset e
	function automatic stt_pkg::token_t close_tok(stt_pkg::scan_state_t s,
			logic [POS_W:0] ts, logic [POS_W-1:0] e);
		stt_pkg::token_t r;
		logic [4:0]      k;
		k = word_kind(s.word);
		case (s.mode)
			stt_pkg::MODE_OP:
				r = make_tok(single_op(s.pending_char), s.line_count, ts, '0);
			stt_pkg::MODE_DOT:
				r = make_tok(stt_pkg::K_DOT, s.line_count, ts, '0);
			stt_pkg::MODE_WORD:
				r = make_tok(k, s.line_count, ts, (k == stt_pkg::K_IDENT) ? span(e, ts) : '0);
			stt_pkg::MODE_INT:
				r = make_tok(stt_pkg::K_INT, s.line_count, ts, span(e, ts));
			stt_pkg::MODE_FLOAT:
				r = make_tok(stt_pkg::K_FLOAT, s.line_count, ts, span(e, ts));
			default:
				r = '0;
		endcase
		return r;
	endfunction

	stt_pkg::scan_state_t                       s;
	stt_pkg::token_t [stt_pkg::MAX_RESULTS-1:0] toks;
	logic [POS_W:0]                             ts;
	logic [POS_W-1:0]                           bp;
	logic [1:0]                                 n;
	logic                                       taken;
	logic [7:0]                                 c;
	logic [5:0]                                 op;

	always_comb begin
		s     = state;
		ts    = tok_start;
		bp    = pos;
		toks  = '0;
		n     = 2'd0;
		taken = 1'b0;
		c     = item.source_byte;
		op    = simple_op(c);

		if (state.mode == stt_pkg::MODE_ERR) begin
			// drop bytes until the end of the source
			if (item.last_byte) begin
				s.mode         = stt_pkg::MODE_IDLE;
				s.pending_char = 8'd0;
				s.line_count   = first_line;
				s.word         = '0;
				bp             = '0;
				ts             = '0;
			end else if (pos < POS_W'(MAX_BYTES)) begin
				bp = pos + POS_W'(1);
			end
		end else begin
			case (s.mode)
				stt_pkg::MODE_OP: begin
					if (c == stt_pkg::CH_EQ) begin
						toks[n] = make_tok(single_op(s.pending_char) - 5'd1, s.line_count, ts, '0);
						n       = n + 2'd1;
						s.mode  = stt_pkg::MODE_IDLE;
						taken   = 1'b1;
					end
				end
				stt_pkg::MODE_DOT: begin
					if (is_digit(c)) begin
						s.mode = stt_pkg::MODE_FLOAT;
						taken  = 1'b1;
					end
				end
				stt_pkg::MODE_STR: begin
					taken = 1'b1;
					if (c == stt_pkg::CH_QUOTE) begin
						toks[n] = make_tok(stt_pkg::K_STRING, s.line_count, ts, span(pos, ts));
						n       = n + 2'd1;
						s.mode  = stt_pkg::MODE_IDLE;
					end
				end
				stt_pkg::MODE_WORD: begin
					if (is_alpha(c)) begin
						s.word = word_add(s.word, c);
						taken  = 1'b1;
					end
				end
				stt_pkg::MODE_INT: begin
					if (is_digit(c)) begin
						taken = 1'b1;
					end else if (c == stt_pkg::CH_DOT) begin
						s.mode = stt_pkg::MODE_FLOAT;
						taken  = 1'b1;
					end
				end
				stt_pkg::MODE_FLOAT: begin
					if (is_digit(c)) taken = 1'b1;
				end
				default: ;
			endcase

			if (!taken) begin
				if (close_has(s.mode)) begin
					toks[n] = close_tok(s, ts, pos);
					n       = n + 2'd1;
				end
				s.mode = stt_pkg::MODE_IDLE;
				if (op[5]) begin
					toks[n] = make_tok(op[4:0], s.line_count, {1'b0, pos}, '0);
					n       = n + 2'd1;
				end else begin
					case (c)
						stt_pkg::CH_EQ, stt_pkg::CH_LT, stt_pkg::CH_GT, stt_pkg::CH_BANG: begin
							s.mode         = stt_pkg::MODE_OP;
							s.pending_char = c;
							ts             = {1'b0, pos};
						end
						stt_pkg::CH_DOT: begin
							s.mode = stt_pkg::MODE_DOT;
							ts     = {1'b0, pos};
						end
						stt_pkg::CH_QUOTE: begin
							s.mode = stt_pkg::MODE_STR;
							ts     = {1'b0, pos} + (POS_W+1)'(1);
						end
						stt_pkg::CH_LF: begin
							if (s.line_count != stt_pkg::LINE_MAX)
								s.line_count = s.line_count + 16'd1;
						end
						stt_pkg::CH_CR, stt_pkg::CH_SPACE: ;
						default: begin
							if (is_alpha(c)) begin
								s.mode = stt_pkg::MODE_WORD;
								ts     = {1'b0, pos};
								s.word = word_add('0, c);
							end else if (is_digit(c)) begin
								s.mode = stt_pkg::MODE_INT;
								ts     = {1'b0, pos};
							end else begin
								toks[n] = make_tok(stt_pkg::K_BADCHAR, s.line_count, {1'b0, pos}, '0);
								n       = n + 2'd1;
								s.mode  = stt_pkg::MODE_ERR;
							end
						end
					endcase
				end
			end

			if (pos < POS_W'(MAX_BYTES))
				bp = pos + POS_W'(1);

			if (item.last_byte) begin
				if (s.mode == stt_pkg::MODE_STR) begin
					toks[n] = make_tok(stt_pkg::K_UNCLOSED, s.line_count, ts, '0);
					n       = n + 2'd1;
				end else if (s.mode != stt_pkg::MODE_ERR) begin
					if (close_has(s.mode)) begin
						toks[n] = close_tok(s, ts, bp);
						n       = n + 2'd1;
					end
					toks[n] = make_tok(stt_pkg::K_EOF, s.line_count, {1'b0, bp}, '0);
					n       = n + 2'd1;
				end
				s.mode         = stt_pkg::MODE_IDLE;
				s.pending_char = 8'd0;
				s.line_count   = first_line;
				s.word         = '0;
				bp             = '0;
				ts             = '0;
			end
		end

		if (n != 2'd0)
			toks[n - 2'd1].last_token = 1'b1;
	end

	assign next_state = s;
	assign next_pos   = bp;
	assign next_start = ts;
	assign tokens     = toks;
	assign count      = n;

endmodule

/* hdl/stt_outbuf.sv */
// Result buffer: holds up to three tokens of one byte and hands them out in order.
module stt_outbuf (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       load,
	input  stt_pkg::token_t [stt_pkg::MAX_RESULTS-1:0] load_tokens,
	input  logic [1:0]                                 load_count,
	input  logic                                       out_stall,
	output logic                                       can_load,
	output logic                                       out_valid,
	output stt_pkg::token_t                            out_token
);

	stt_pkg::token_t [stt_pkg::MAX_RESULTS-1:0] tok_q;
	logic [1:0]                                 count_q;
	logic                                       take;

	assign out_valid = (count_q != 2'd0);
	assign out_token = tok_q[0];
	assign take      = out_valid && !out_stall;
	assign can_load  = (count_q == 2'd0) || ((count_q == 2'd1) && take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (load) begin
			count_q <= load_count;
		end else if (take) begin
			count_q <= count_q - 2'd1;
		end
	end

	// advance the head on every taken item
	always_ff @(posedge clk) begin
		if (load) begin
			tok_q <= load_tokens;
		end else if (take) begin
			tok_q[0] <= tok_q[1];
			tok_q[1] <= tok_q[2];
		end
	end

endmodule

/* hdl/source_text_tokenizer_core.sv */
// Top level of the source text tokenizer: input register, scan state and result buffer.
// Path: an accepted byte is captured in the input register and scanned there; on commit
//   its tokens are loaded into the result buffer, which offers them on out_token.
// Throughput: one byte per cycle while no byte yields more than one token and the
//   output does not stall; a byte with more tokens holds the next token-yielding byte
//   in the input register, as the result buffer has one token-wide output port.
// Reset (arst_n low, asynchronous): scanner idle, offset zero, first_line back to 1.
module source_text_tokenizer_core #(
	parameter int unsigned MAX_SOURCE_BYTES = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  stt_pkg::src_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output stt_pkg::token_t     out_token,
	input  logic                cfg_write_en,
	input  logic [15:0]         cfg_write_data
);

	// Byte offset saturates at MAX_SOURCE_BYTES, so it needs room for that value.
	localparam int POS_W = $clog2(MAX_SOURCE_BYTES + 1);

	// Input register
	stt_pkg::src_item_t item_s1;
	logic               valid_s1;

	// Scanner state
	stt_pkg::scan_state_t state_q;
	logic [POS_W-1:0]     pos_q;
	logic [POS_W:0]       start_q;
	logic [15:0]          first_line_q;

	// Scan results for the byte in the input register
	stt_pkg::scan_state_t                       next_state;
	logic [POS_W-1:0]                           next_pos;
	logic [POS_W:0]                             next_start;
	stt_pkg::token_t [stt_pkg::MAX_RESULTS-1:0] step_tokens;
	logic [1:0]                                 step_n;

	logic can_load;
	logic commit;
	logic accept;

	// Commit the held byte once the result buffer is empty or is handing out its last token;
	// a byte that yields nothing commits at once.
	assign commit   = valid_s1 && ((step_n == 2'd0) || can_load);
	assign in_stall = valid_s1 && !commit;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	// hold the payload while stalled
	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= in_item;
	end

	stt_step #(
		.POS_W     (POS_W),
		.MAX_BYTES (MAX_SOURCE_BYTES)
	) u_step (
		.state      (state_q),
		.pos        (pos_q),
		.tok_start  (start_q),
		.first_line (first_line_q),
		.item       (item_s1),
		.next_state (next_state),
		.next_pos   (next_pos),
		.next_start (next_start),
		.tokens     (step_tokens),
		.count      (step_n)
	);

	// Advance scanner state on commit. A first_line write before any byte of the
	// current source also reloads the line counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= stt_pkg::MODE_IDLE;
			state_q.pending_char <= 8'd0;
			state_q.line_count   <= stt_pkg::FIRST_LINE_RST;
			state_q.word         <= '0;
			pos_q                <= '0;
			start_q              <= '0;
			first_line_q         <= stt_pkg::FIRST_LINE_RST;
		end else begin
			if (cfg_write_en)
				first_line_q <= cfg_write_data;
			if (commit) begin
				state_q <= next_state;
				pos_q   <= next_pos;
				start_q <= next_start;
			end else if (cfg_write_en && (pos_q == '0)) begin
				state_q.line_count <= cfg_write_data;
			end
		end
	end

	stt_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (commit && (step_n != 2'd0)),
		.load_tokens (step_tokens),
		.load_count  (step_n),
		.out_stall   (out_stall),
		.can_load    (can_load),
		.out_valid   (out_valid),
		.out_token   (out_token)
	);

`ifndef SYNTHESIS
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (step_n != 2'd0) |=> out_valid)
		else $error("tokens committed but none offered");

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (state_q.mode == stt_pkg::MODE_ERR) |-> (step_n == 2'd0))
		else $error("token produced after an invalid character");

	a_new_source: assert property (@(posedge clk) disable iff (!arst_n)
		commit && item_s1.last_byte |=> (pos_q == '0) && (state_q.mode == stt_pkg::MODE_IDLE))
		else $error("scanner not restarted after the final byte");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((out_token.token_kind == stt_pkg::K_EOF) ||
		(out_token.token_kind == stt_pkg::K_UNCLOSED)) |-> out_token.last_token)
		else $error("end-of-source token not marked last");
`endif

endmodule
